// ===== hw/rtl/chb_pkg.sv =====
// ----------------------------------------------------------------------------
// chb_pkg
// Shared widths, constants, the arctangent table and the word types of the
// compass heading datapath.
// ----------------------------------------------------------------------------
package chb_pkg;

    localparam int CORDIC_STAGES = 16;

    localparam int IN_W   = 16;
    localparam int FRAC_W = 16;
    localparam int XY_W   = IN_W + FRAC_W + 4;
    localparam int Z_W    = 32;
    localparam int ANG_W  = Z_W - FRAC_W;
    localparam int OFF_W  = 15;
    localparam int HDG_W  = 15;
    localparam int SUM_W  = 18;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_HEADING_OFFSET = 3'd0;

    localparam logic signed [Z_W-1:0]   HALF_TURN_Z = 32'sd754974720;
    localparam logic signed [Z_W-1:0]   ROUND_BIAS  = 32'sd32768;
    localparam logic signed [OFF_W-1:0] OFFSET_MAX  = 15'sd11520;
    localparam logic signed [OFF_W-1:0] OFFSET_MIN  = -15'sd11520;
    localparam logic signed [SUM_W-1:0] FULL_TURN   = 18'sd23040;
    localparam logic signed [SUM_W-1:0] TWO_TURNS   = 18'sd46080;

    typedef struct packed {
        logic                    valid;
        logic signed [ANG_W-1:0] angle;
    } t_cordic_out;

    // atan(2^-i) in degrees * 2^22
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 32'sd188743680;
            1:       v = 32'sd111421900;
            2:       v = 32'sd58872272;
            3:       v = 32'sd29884485;
            4:       v = 32'sd15000234;
            5:       v = 32'sd7507429;
            6:       v = 32'sd3754631;
            7:       v = 32'sd1877430;
            8:       v = 32'sd938729;
            9:       v = 32'sd469366;
            10:      v = 32'sd234683;
            11:      v = 32'sd117342;
            12:      v = 32'sd58671;
            13:      v = 32'sd29335;
            14:      v = 32'sd14668;
            15:      v = 32'sd7334;
            16:      v = 32'sd3667;
            17:      v = 32'sd1833;
            18:      v = 32'sd917;
            19:      v = 32'sd458;
            20:      v = 32'sd229;
            21:      v = 32'sd115;
            22:      v = 32'sd57;
            23:      v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/chb_cordic.sv =====
// ----------------------------------------------------------------------------
// chb_cordic
// Pipelined vectoring CORDIC: quadrant fold, one register stage per
// iteration, then rounding of the angle to 1/64 degree.
// ----------------------------------------------------------------------------
module chb_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [chb_pkg::IN_W-1:0]   i_field_x,
    input  logic signed [chb_pkg::IN_W-1:0]   i_field_y,
    output chb_pkg::t_cordic_out              o_out,
    input  logic                              i_stall
);
    import chb_pkg::*;

    logic signed [XY_W-1:0]  r_x [0:CORDIC_STAGES];
    logic signed [XY_W-1:0]  r_y [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]   r_z [0:CORDIC_STAGES];
    logic                    r_zero [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0]  r_v;
    logic                    r_rnd_v;
    logic signed [ANG_W-1:0] r_ang;
    logic [CORDIC_STAGES+1:0] w_en;

    logic signed [XY_W-1:0]  w_xe;
    logic signed [XY_W-1:0]  w_ye;
    logic                    w_xneg;
    logic signed [XY_W-1:0]  n_x0;
    logic signed [XY_W-1:0]  n_y0;
    logic signed [Z_W-1:0]   n_z0;
    logic signed [Z_W-1:0]   n_rnd;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_en[CORDIC_STAGES+1] = !r_rnd_v || !i_stall;
        for (int k = CORDIC_STAGES; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_rnd_v <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= CORDIC_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_en[CORDIC_STAGES+1]) begin
                r_rnd_v <= r_v[CORDIC_STAGES];
            end
        end
    end

    // quadrant fold into the right half plane
    always_comb begin
        w_xe   = {{(XY_W-IN_W){i_field_x[IN_W-1]}}, i_field_x};
        w_ye   = {{(XY_W-IN_W){i_field_y[IN_W-1]}}, i_field_y};
        w_xneg = i_field_x[IN_W-1];
        if (w_xneg) begin
            n_x0 = (-w_xe) <<< FRAC_W;
            n_y0 = (-w_ye) <<< FRAC_W;
            n_z0 = i_field_y[IN_W-1] ? -HALF_TURN_Z : HALF_TURN_Z;
        end else begin
            n_x0 = w_xe <<< FRAC_W;
            n_y0 = w_ye <<< FRAC_W;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_field_x == '0) && (i_field_y == '0);
        end
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (w_en[gi+1]) begin
                if (!r_y[gi][XY_W-1]) begin
                    r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] + atan_entry(gi);
                end else begin
                    r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] - atan_entry(gi);
                end
                r_zero[gi+1] <= r_zero[gi];
            end
        end
    end

    // round half up to 1/64 degree
    assign n_rnd = r_z[CORDIC_STAGES] + ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (w_en[CORDIC_STAGES+1]) begin
            r_ang <= r_zero[CORDIC_STAGES] ? '0 : n_rnd[Z_W-1:FRAC_W];
        end
    end

    assign o_out.valid = r_rnd_v;
    assign o_out.angle = r_ang;

endmodule

// ===== hw/rtl/compass_heading_from_field_top.sv =====
// ----------------------------------------------------------------------------
// compass_heading_from_field_top
// Compass heading from a horizontal field pair: CORDIC atan2, offset and
// wrap into 0..23039 in 1/64 degree, with an APB offset register.
// Stages: input fold, one per CORDIC iteration, rounding, offset sum, wrap.
// Throughput: one word per cycle while no stall holds the pipeline; every CORDIC iteration has its own stage.
// Stalls hold each stage only while the stage after it is full.
// Reset (synchronous, active low) empties the pipeline and clears the offset.
// ----------------------------------------------------------------------------
module compass_heading_from_field_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [chb_pkg::IN_W-1:0]   i_field_x,
    input  logic signed [chb_pkg::IN_W-1:0]   i_field_y,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [chb_pkg::HDG_W-1:0]         o_heading,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chb_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import chb_pkg::*;

    t_cordic_out             w_cordic;
    logic                    w_cordic_stall;

    logic signed [OFF_W-1:0] r_offset;
    logic signed [OFF_W-1:0] w_off_sat;

    logic                    r_sum_v;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic                    r_out_v;
    logic [HDG_W-1:0]        r_heading;
    logic signed [SUM_W-1:0] n_wrap;
    logic                    w_en_sum;
    logic                    w_en_out;

    chb_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_field_x (i_field_x),
        .i_field_y (i_field_y),
        .o_out     (w_cordic),
        .i_stall   (w_cordic_stall)
    );

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_HEADING_OFFSET)
                  ? {{(32-OFF_W){r_offset[OFF_W-1]}}, r_offset} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_HEADING_OFFSET) begin
            r_offset <= pwdata[OFF_W-1:0];
        end
    end

    always_comb begin
        if (r_offset > OFFSET_MAX) begin
            w_off_sat = OFFSET_MAX;
        end else if (r_offset < OFFSET_MIN) begin
            w_off_sat = OFFSET_MIN;
        end else begin
            w_off_sat = r_offset;
        end
    end

    assign w_en_out       = !r_out_v || !i_stall;
    assign w_en_sum       = !r_sum_v || w_en_out;
    assign w_cordic_stall = !w_en_sum;

    assign n_sum = FULL_TURN
                 - {{(SUM_W-ANG_W){w_cordic.angle[ANG_W-1]}}, w_cordic.angle}
                 + {{(SUM_W-OFF_W){w_off_sat[OFF_W-1]}}, w_off_sat};

    always_comb begin
        if (r_sum < 0) begin
            n_wrap = r_sum + FULL_TURN;
        end else if (r_sum >= TWO_TURNS) begin
            n_wrap = r_sum - TWO_TURNS;
        end else if (r_sum >= FULL_TURN) begin
            n_wrap = r_sum - FULL_TURN;
        end else begin
            n_wrap = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en_sum) begin
                r_sum_v <= w_cordic.valid;
            end
            if (w_en_out) begin
                r_out_v <= r_sum_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_sum) begin
            r_sum <= n_sum;
        end
        if (w_en_out) begin
            r_heading <= n_wrap[HDG_W-1:0];
        end
    end

    assign o_valid   = r_out_v;
    assign o_heading = r_heading;

endmodule

// ===== hw/rtl/chb_checker.sv =====
// ----------------------------------------------------------------------------
// chb_checker
// Port-level checks on the compass heading block, bound to the top level.
// ----------------------------------------------------------------------------
module chb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [chb_pkg::HDG_W-1:0]         o_heading,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [chb_pkg::ADDR_W-1:0]        paddr,
    input logic [31:0]                       pwdata,
    input logic [31:0]                       prdata
);
    import chb_pkg::*;

    localparam logic [HDG_W-1:0] HEADING_LIMIT = 15'd23040;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading < HEADING_LIMIT)
        else $error("heading outside one turn");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register empty");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_heading))
        else $error("stalled output word changed");

    a_offset_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr == ADDR_HEADING_OFFSET
        ##1 paddr == ADDR_HEADING_OFFSET
        |-> prdata[OFF_W-1:0] == $past(pwdata[OFF_W-1:0]))
        else $error("offset register reads back wrong");

endmodule

bind compass_heading_from_field_top chb_checker u_chb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_heading (o_heading),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

// ===== sim/tb_compass_heading_from_field_top.sv =====
// ----------------------------------------------------------------------------
// tb_compass_heading_from_field_top
// Self-checking bench for the compass heading pipeline. A fixed-point CORDIC
// atan2 model predicts each heading from the field pair and the current
// offset. Results are compared in order against the predicted headings.
// Directed axis and corner pairs run first. Random phases follow, each but one
// with a new offset, including both saturation limits; that one writes an
// ignored register address instead. Random gaps are inserted on the sender
// side and random stalls on the receiver side.
// ----------------------------------------------------------------------------
module tb_compass_heading_from_field_top;

    import chb_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          PHASE_WORDS   = 231;
    localparam int          NUM_PHASES    = 8;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int          ATAN_LEN      = 24;
    localparam longint      TURN_64THS    = 23040;
    localparam longint      HALF_TURN_Q22 = 64'sd754974720;
    localparam longint      OFFSET_CLAMP  = 11520;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    typedef struct {
        logic signed [IN_W-1:0] fx;
        logic signed [IN_W-1:0] fy;
        logic [HDG_W-1:0]       heading;
    } t_heading_expect;

    class heading_scoreboard;
        longint          atan_q22 [ATAN_LEN];
        longint          offset_raw;
        t_heading_expect expected_headings [$];
        int              errors;

        function new();
            atan_q22 = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                         3754631, 1877430, 938729, 469366, 234683, 117342,
                         58671, 29335, 14668, 7334, 3667, 1833,
                         917, 458, 229, 115, 57, 29};
            offset_raw = 0;
            errors     = 0;
        endfunction

        function void set_offset(logic [OFF_W-1:0] val);
            logic signed [OFF_W-1:0] sv;
            sv         = val;
            offset_raw = sv;
        endfunction

        function logic [HDG_W-1:0] predict_heading(logic signed [IN_W-1:0] fx,
                                                   logic signed [IN_W-1:0] fy);
            longint x, y, z, xs, ys, nx, ny, ang, off, h;
            x = fx;
            y = fy;
            z = 0;
            if (x == 0 && y == 0) begin
                ang = 0;
            end else begin
                if (x < 0) begin
                    z = (y >= 0) ? HALF_TURN_Q22 : -HALF_TURN_Q22;
                    x = -x;
                    y = -y;
                end
                xs = x * 65536;
                ys = y * 65536;
                for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
                    if (ys >= 0) begin
                        nx = xs + (ys >>> i);
                        ny = ys - (xs >>> i);
                        z  = z + atan_q22[i];
                    end else begin
                        nx = xs - (ys >>> i);
                        ny = ys + (xs >>> i);
                        z  = z - atan_q22[i];
                    end
                    xs = nx;
                    ys = ny;
                end
                ang = (z + 32768) >>> 16;
            end
            off = offset_raw;
            if (off > OFFSET_CLAMP) off = OFFSET_CLAMP;
            if (off < -OFFSET_CLAMP) off = -OFFSET_CLAMP;
            h = TURN_64THS - ang + off;
            h = h % TURN_64THS;
            if (h < 0) h = h + TURN_64THS;
            return h[HDG_W-1:0];
        endfunction

        function void note_word(logic signed [IN_W-1:0] fx, logic signed [IN_W-1:0] fy);
            t_heading_expect e;
            e.fx      = fx;
            e.fy      = fy;
            e.heading = predict_heading(fx, fy);
            expected_headings.push_back(e);
        endfunction

        function void check_heading(logic [HDG_W-1:0] actual);
            t_heading_expect e;
            if (expected_headings.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected heading word %0d", actual);
                return;
            end
            e = expected_headings.pop_front();
            if (actual !== e.heading) begin
                errors++;
                if (errors <= 10)
                    $display("heading mismatch x=%0d y=%0d: expected %0d got %0d",
                             e.fx, e.fy, e.heading, actual);
            end
        endfunction

        function int pending();
            return expected_headings.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [IN_W-1:0] i_field_x;
    logic signed [IN_W-1:0] i_field_y;
    logic                   o_valid;
    logic                   i_stall;
    logic [HDG_W-1:0]       o_heading;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    heading_scoreboard sb;
    bit                quiet_tail;
    int                cycles = 0;
    int unsigned       tx_calm;
    int unsigned       rx_calm;
    int unsigned       stall_left;

    compass_heading_from_field_top u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_field_x (i_field_x),
        .i_field_y (i_field_y),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_heading (o_heading),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result check first, then note the accepted word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_heading(o_heading);
            if (i_valid && !o_stall)
                sb.note_word(i_field_x, i_field_y);
        end
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        int unsigned r;
        if (quiet_tail || !i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
            rx_calm    = 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left = stall_left - 1;
        end else if (rx_calm > 0) begin
            i_stall <= 1'b0;
            rx_calm = rx_calm - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                rx_calm = $urandom_range(30, 150);
                i_stall <= 1'b0;
            end else if (r < 18) begin
                stall_left = $urandom_range(1, 16) - 1;
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [IN_W-1:0] pick_field();
        logic signed [IN_W-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = 16'sd1;
                    2:       v = -16'sd1;
                    3:       v = 16'sh7FFF;
                    default: v = 16'sh8000;
                endcase
            end
            1:       v = IN_W'($urandom_range(0, 16) - 8);
            default: v = IN_W'($urandom());
        endcase
        return v;
    endfunction

    task automatic feed_word(input logic signed [IN_W-1:0] fx,
                             input logic signed [IN_W-1:0] fy);
        int unsigned gap;
        int unsigned r;
        gap = 0;
        if (!quiet_tail) begin
            if (tx_calm > 0) begin
                tx_calm--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    tx_calm = $urandom_range(30, 150);
                else if (r < 20)
                    gap = $urandom_range(1, 16);
            end
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_field_x <= fx;
        i_field_y <= fy;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_for_headings();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [OFF_W-1:0] val);
        logic [31:0] word;
        word           = $urandom();
        word[OFF_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_HEADING_OFFSET)
            sb.set_offset(val);
    endtask

    initial begin
        logic [OFF_W-1:0] off;
        sb         = new();
        quiet_tail = 1'b0;
        tx_calm    = 0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_field_x  <= '0;
        i_field_y  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // axes, quadrants and extremes at the reset offset
        feed_word(16'sd0, 16'sd0);
        feed_word(16'sd1, 16'sd0);
        feed_word(-16'sd1, 16'sd0);
        feed_word(16'sd0, 16'sd1);
        feed_word(16'sd0, -16'sd1);
        feed_word(16'sh8000, 16'sh8000);
        feed_word(16'sh7FFF, 16'sh7FFF);
        feed_word(16'sh8000, 16'sh7FFF);
        feed_word(16'sh7FFF, 16'sh8000);
        feed_word(16'sh8000, 16'sd0);
        feed_word(16'sd0, 16'sh8000);
        feed_word(16'sd0, 16'sh7FFF);
        feed_word(16'sh7FFF, 16'sd0);
        feed_word(-16'sd1, -16'sd1);
        feed_word(-16'sd1, 16'sd1);
        feed_word(16'sd1, -16'sd1);
        feed_word(16'sh7FFF, 16'sd1);
        feed_word(16'sh8000, -16'sd1);
        feed_word(16'sh8000, 16'sd1);
        feed_word(16'sd3, 16'sd4);
        feed_word(-16'sd300, -16'sd400);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_headings();
            case (p)
                0:       off = 15'd11520;
                1:       off = -15'sd11520;
                2:       off = 15'h3FFF;
                3:       off = 15'h4000;
                4:       off = OFF_W'($urandom_range(0, 32767));
                6:       off = '0;
                default: off = OFF_W'($urandom_range(0, 23040) - 11520);
            endcase
            if (p == 5)
                write_reg(ADDR_UNUSED, OFF_W'($urandom_range(0, 32767)));
            else
                write_reg(ADDR_HEADING_OFFSET, off);
            if (p == NUM_PHASES - 1)
                quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                feed_word(pick_field(), pick_field());
        end

        wait_for_headings();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
